FILE: rtl/scrd_pkg.sv
// Shared constants, types and tables for the spherical camera ray direction block.
// No dependencies; every other file in rtl/ imports this package.
package scrd_pkg;

    // Port field widths
    localparam int PT_W       = 32;
    localparam int LIM_W      = 16;
    localparam int RES_W      = 14;
    localparam int PIX_W      = 31;
    localparam int BASIS_W    = 48;
    localparam int COMP_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Angle division: |point * limit| * 512 over pixel_size * resolution
    localparam int PROD_W = 47;
    localparam int PAD_W  = 9;
    localparam int MAG_W  = PROD_W + PAD_W;
    localparam int DEN_W  = PIX_W + RES_W;

    // Angles in degrees with 16 fraction bits, reduced to [0, 360)
    localparam int ANG_W = 25;
    localparam logic [ANG_W-1:0] ANG_FULL     = 25'd23592960;
    localparam logic [ANG_W-1:0] ANG_3QUARTER = 25'd17694720;
    localparam logic [ANG_W-1:0] ANG_HALF     = 25'd11796480;
    localparam logic [ANG_W-1:0] ANG_QUARTER  = 25'd5898240;

    // Rotation datapath: Q.30 samples, residual angle in Q.16 degrees
    localparam int Z_W      = 25;
    localparam int CW       = 34;
    localparam int FRAC     = 30;
    localparam int ATAN_LEN = 24;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_DEG [ATAN_LEN] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HRES,
        CFG_VRES,
        CFG_PIXEL,
        CFG_AZIMUTH,
        CFG_ELEVATION,
        CFG_RIGHT,
        CFG_UP,
        CFG_BACK
    } t_cfg_idx;

    // Pipeline control handed to every stage group
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

FILE: rtl/scrd_if.sv
// Channel interfaces: sample points in, ray directions out, register writes.
// Depends on scrd_pkg for field widths.
interface scrd_point_if import scrd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface scrd_dir_if import scrd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [COMP_W-1:0] direction_x;
    logic signed [COMP_W-1:0] direction_y;
    logic signed [COMP_W-1:0] direction_z;

    modport source (output valid, direction_x, direction_y, direction_z, input ready);
    modport sink   (input valid, direction_x, direction_y, direction_z, output ready);
endinterface

interface scrd_cfg_if import scrd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/spherical_camera_ray_direction.sv
// Spherical panoramic camera ray direction, fully pipelined.
// Each item runs through the 56-step angle divider, the rotation stages (at most 24 rotation
// stages) and the three-stage basis mix.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous, clears all valid bits and loads the default camera registers.
module spherical_camera_ray_direction import scrd_pkg::*; #(
    parameter int SINCOS_STAGES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    scrd_point_if.sink      i_point,
    scrd_dir_if.source      o_dir,
    scrd_cfg_if.sink        i_cfg
);

    logic [RES_W-1:0]   r_hres;
    logic [RES_W-1:0]   r_vres;
    logic [PIX_W-1:0]   r_pixel;
    logic [LIM_W-1:0]   r_azimuth;
    logic [LIM_W-1:0]   r_elevation;
    logic [BASIS_W-1:0] r_right;
    logic [BASIS_W-1:0] r_up;
    logic [BASIS_W-1:0] r_back;
    logic [DEN_W-1:0]   r_den_h;
    logic [DEN_W-1:0]   r_den_v;

    logic [PIX_W-1:0]   w_pix;
    logic [RES_W-1:0]   w_hres;
    logic [RES_W-1:0]   w_vres;

    logic               w_en;
    t_stage_ctl         w_in_ctl;
    t_stage_ctl         w_phi_ctl;
    t_stage_ctl         w_theta_ctl;
    t_stage_ctl         w_mix_ctl;
    logic               w_phi_v;
    logic               w_theta_v;
    logic [ANG_W-1:0]   w_phi;
    logic [ANG_W-1:0]   w_theta;
    logic               w_sp_v;
    logic               w_st_v;
    logic signed [CW-1:0] w_sin_p;
    logic signed [CW-1:0] w_cos_p;
    logic signed [CW-1:0] w_sin_t;
    logic signed [CW-1:0] w_cos_t;
    logic               w_out_v;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hres      <= RES_W'(640);
            r_vres      <= RES_W'(480);
            r_pixel     <= PIX_W'(65536);
            r_azimuth   <= LIM_W'(15360);
            r_elevation <= LIM_W'(46080);
            r_right     <= BASIS_W'(48'h0000_0000_4000);
            r_up        <= BASIS_W'(48'h0000_4000_0000);
            r_back      <= BASIS_W'(48'h4000_0000_0000);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_HRES:      r_hres      <= i_cfg.data[RES_W-1:0];
                CFG_VRES:      r_vres      <= i_cfg.data[RES_W-1:0];
                CFG_PIXEL:     r_pixel     <= i_cfg.data[PIX_W-1:0];
                CFG_AZIMUTH:   r_azimuth   <= i_cfg.data[LIM_W-1:0];
                CFG_ELEVATION: r_elevation <= i_cfg.data[LIM_W-1:0];
                CFG_RIGHT:     r_right     <= i_cfg.data[BASIS_W-1:0];
                CFG_UP:        r_up        <= i_cfg.data[BASIS_W-1:0];
                CFG_BACK:      r_back      <= i_cfg.data[BASIS_W-1:0];
                default:       r_hres      <= r_hres;
            endcase
        end
    end

    // Divisors, a zero field counting as one
    assign w_pix  = (r_pixel == '0) ? PIX_W'(1) : r_pixel;
    assign w_hres = (r_hres == '0) ? RES_W'(1) : r_hres;
    assign w_vres = (r_vres == '0) ? RES_W'(1) : r_vres;

    always_ff @(posedge i_clk) begin
        r_den_h <= {{RES_W{1'b0}}, w_pix} * {{PIX_W{1'b0}}, w_hres};
        r_den_v <= {{RES_W{1'b0}}, w_pix} * {{PIX_W{1'b0}}, w_vres};
    end

    // Global advance: move whenever the output register is free or being taken
    assign w_en          = !w_out_v || o_dir.ready;
    assign i_point.ready = w_en;
    assign w_in_ctl      = '{en: w_en, valid: i_point.valid};
    assign w_phi_ctl     = '{en: w_en, valid: w_phi_v};
    assign w_theta_ctl   = '{en: w_en, valid: w_theta_v};
    assign w_mix_ctl     = '{en: w_en, valid: w_sp_v};

    scrd_moddiv u_div_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .i_point (i_point.point_x),
        .i_limit (r_azimuth),
        .i_den   (r_den_h),
        .i_bias  (ANG_HALF),
        .o_valid (w_phi_v),
        .o_angle (w_phi)
    );

    scrd_moddiv u_div_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .i_point (i_point.point_y),
        .i_limit (r_elevation),
        .i_den   (r_den_v),
        .i_bias  (ANG_QUARTER),
        .o_valid (w_theta_v),
        .o_angle (w_theta)
    );

    scrd_cordic #(.STAGES(SINCOS_STAGES)) u_sc_phi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_phi_ctl),
        .i_angle (w_phi),
        .o_valid (w_sp_v),
        .o_sin   (w_sin_p),
        .o_cos   (w_cos_p)
    );

    scrd_cordic #(.STAGES(SINCOS_STAGES)) u_sc_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_theta_ctl),
        .i_angle (w_theta),
        .o_valid (w_st_v),
        .o_sin   (w_sin_t),
        .o_cos   (w_cos_t)
    );

    scrd_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mix_ctl),
        .i_sin_t (w_sin_t),
        .i_cos_t (w_cos_t),
        .i_sin_p (w_sin_p),
        .i_cos_p (w_cos_p),
        .i_right (r_right),
        .i_up    (r_up),
        .i_back  (r_back),
        .o_valid (w_out_v),
        .o_dx    (o_dir.direction_x),
        .o_dy    (o_dir.direction_y),
        .o_dz    (o_dir.direction_z)
    );

    assign o_dir.valid = w_out_v;

    // Both angle paths carry the same item in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_phi_v == w_theta_v)
        else $error("angle dividers out of step");

    a_sc_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sp_v == w_st_v)
        else $error("sine/cosine units out of step");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_dir.valid |-> i_point.ready)
        else $error("input stalled with empty output");

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_dir.valid)
        else $error("output valid after reset");

endmodule

FILE: rtl/scrd_moddiv.sv
// View angle unit: point * limit * 512 / denominator, one quotient bit per stage,
// with the quotient reduced modulo 360 degrees on the fly. Depends on scrd_pkg.
module scrd_moddiv import scrd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_stage_ctl            i_ctl,
    input  logic signed [PT_W-1:0] i_point,
    input  logic [LIM_W-1:0]      i_limit,
    input  logic [DEN_W-1:0]      i_den,
    input  logic [ANG_W-1:0]      i_bias,
    output logic                  o_valid,
    output logic [ANG_W-1:0]      o_angle
);

    logic [PT_W-1:0]          w_abs;
    logic [PT_W+LIM_W-1:0]    w_prod;

    logic                     r_v   [MAG_W+1];
    logic                     r_neg [MAG_W+1];
    logic [MAG_W-1:0]         r_num [MAG_W+1];
    logic [DEN_W-1:0]         r_rem [MAG_W+1];
    logic [ANG_W-1:0]         r_qm  [MAG_W+1];

    logic [DEN_W-1:0]         n_rem [MAG_W];
    logic [ANG_W-1:0]         n_qm  [MAG_W];

    logic [ANG_W:0]           w_lo;
    logic [ANG_W:0]           w_hi;
    logic [ANG_W:0]           w_hm;
    logic [ANG_W-1:0]         n_angle;
    logic                     r_out_v;
    logic [ANG_W-1:0]         r_angle;

    // Magnitude of the numerator, sign kept apart
    assign w_abs  = i_point[PT_W-1] ? PT_W'(-i_point) : PT_W'(i_point);
    assign w_prod = w_abs * i_limit;

    // One restoring step per stage, quotient folded modulo a full turn
    for (genvar k = 0; k < MAG_W; k++) begin : g_step
        logic [DEN_W:0]   w_sh;
        logic [DEN_W+1:0] w_diff;
        logic             w_bit;
        logic [ANG_W:0]   w_q2;
        logic [ANG_W+1:0] w_qd;

        assign w_sh   = {r_rem[k], r_num[k][MAG_W-1]};
        assign w_diff = {1'b0, w_sh} - {2'b00, i_den};
        assign w_bit  = ~w_diff[DEN_W+1];
        assign w_q2   = {r_qm[k], w_bit};
        assign w_qd   = {1'b0, w_q2} - {2'b00, ANG_FULL};
        assign n_rem[k] = w_bit ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
        assign n_qm[k]  = w_qd[ANG_W+1] ? w_q2[ANG_W-1:0] : w_qd[ANG_W-1:0];
    end

    // Apply the sign and the bias, back into [0, 360)
    assign w_lo = {1'b0, i_bias} - {1'b0, r_qm[MAG_W]};
    assign w_hi = {1'b0, i_bias} + {1'b0, r_qm[MAG_W]};
    assign w_hm = w_hi - {1'b0, ANG_FULL};

    always_comb begin
        if (r_neg[MAG_W]) begin
            n_angle = w_hm[ANG_W] ? w_hi[ANG_W-1:0] : w_hm[ANG_W-1:0];
        end else begin
            n_angle = w_lo[ANG_W] ? (w_lo[ANG_W-1:0] + ANG_FULL) : w_lo[ANG_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAG_W; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
            for (int k = 0; k < MAG_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_out_v <= r_v[MAG_W];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_neg[0] <= i_point[PT_W-1];
            r_num[0] <= {w_prod[PROD_W-1:0], {PAD_W{1'b0}}};
            r_rem[0] <= '0;
            r_qm[0]  <= '0;
            for (int k = 0; k < MAG_W; k++) begin
                r_neg[k+1] <= r_neg[k];
                r_num[k+1] <= {r_num[k][MAG_W-2:0], 1'b0};
                r_rem[k+1] <= n_rem[k];
                r_qm[k+1]  <= n_qm[k];
            end
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_out_v;
    assign o_angle = r_angle;

endmodule

FILE: rtl/scrd_cordic.sv
// Pipelined sine/cosine: quadrant fold, one rotation per stage, sign restore.
// Depends on scrd_pkg for the arctangent table and datapath widths.
module scrd_cordic import scrd_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_stage_ctl            i_ctl,
    input  logic [ANG_W-1:0]      i_angle,
    output logic                  o_valid,
    output logic signed [CW-1:0]  o_sin,
    output logic signed [CW-1:0]  o_cos
);

    localparam int N = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

    logic signed [ANG_W:0]   w_a;
    logic signed [ANG_W:0]   w_z0;
    logic                    w_neg0;

    logic                    r_v   [N+1];
    logic                    r_neg [N+1];
    logic signed [CW-1:0]    r_x   [N+1];
    logic signed [CW-1:0]    r_y   [N+1];
    logic signed [Z_W-1:0]   r_z   [N+1];

    logic signed [CW-1:0]    n_x [N];
    logic signed [CW-1:0]    n_y [N];
    logic signed [Z_W-1:0]   n_z [N];

    logic                    r_out_v;
    logic signed [CW-1:0]    r_sin;
    logic signed [CW-1:0]    r_cos;

    // Fold into [-90, 90] degrees
    assign w_a = signed'({1'b0, i_angle});

    always_comb begin
        if (i_angle <= ANG_QUARTER) begin
            w_z0   = w_a;
            w_neg0 = 1'b0;
        end else if (i_angle < ANG_3QUARTER) begin
            w_z0   = w_a - signed'({1'b0, ANG_HALF});
            w_neg0 = 1'b1;
        end else begin
            w_z0   = w_a - signed'({1'b0, ANG_FULL});
            w_neg0 = 1'b0;
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < N; k++) begin : g_rot
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;

        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;
        assign n_x[k] = r_z[k][Z_W-1] ? (r_x[k] + w_ys) : (r_x[k] - w_ys);
        assign n_y[k] = r_z[k][Z_W-1] ? (r_y[k] - w_xs) : (r_y[k] + w_xs);
        assign n_z[k] = r_z[k][Z_W-1] ? (r_z[k] + ATAN_DEG[k]) : (r_z[k] - ATAN_DEG[k]);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
            for (int k = 0; k < N; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_out_v <= r_v[N];
        end
    end

    // Advance payload; undo the half-turn fold at the end
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= w_z0[Z_W-1:0];
            r_neg[0] <= w_neg0;
            for (int k = 0; k < N; k++) begin
                r_x[k+1]   <= n_x[k];
                r_y[k+1]   <= n_y[k];
                r_z[k+1]   <= n_z[k];
                r_neg[k+1] <= r_neg[k];
            end
            r_sin <= r_neg[N] ? -r_y[N] : r_y[N];
            r_cos <= r_neg[N] ? -r_x[N] : r_x[N];
        end
    end

    assign o_valid = r_out_v;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

FILE: rtl/scrd_mix.sv
// Basis mix: spherical coefficients, nine coefficient-by-basis products, then
// rounded and saturated sums per component. Depends on scrd_pkg.
module scrd_mix import scrd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_stage_ctl              i_ctl,
    input  logic signed [CW-1:0]    i_sin_t,
    input  logic signed [CW-1:0]    i_cos_t,
    input  logic signed [CW-1:0]    i_sin_p,
    input  logic signed [CW-1:0]    i_cos_p,
    input  logic [BASIS_W-1:0]      i_right,
    input  logic [BASIS_W-1:0]      i_up,
    input  logic [BASIS_W-1:0]      i_back,
    output logic                    o_valid,
    output logic signed [COMP_W-1:0] o_dx,
    output logic signed [COMP_W-1:0] o_dy,
    output logic signed [COMP_W-1:0] o_dz
);

    localparam int PW   = CW + COMP_W;
    localparam int SW   = PW + 2;
    localparam int RW   = SW - FRAC;
    localparam logic signed [SW-1:0] HALF_LSB = SW'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [RW-1:0] SAT_HI   = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO   = -RW'(32768);

    logic signed [2*CW-1:0]   w_ss;
    logic signed [2*CW-1:0]   w_sc;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic signed [CW-1:0]     r_a;
    logic signed [CW-1:0]     r_b;
    logic signed [CW-1:0]     r_c;
    logic signed [PW-1:0]     r_pu [3];
    logic signed [PW-1:0]     r_pv [3];
    logic signed [PW-1:0]     r_pw [3];
    logic signed [COMP_W-1:0] n_dir [3];
    logic signed [COMP_W-1:0] r_dir [3];

    assign w_ss = i_sin_t * i_sin_p;
    assign w_sc = i_sin_t * i_cos_p;

    // Per-component sum, round half up, saturate
    for (genvar k = 0; k < 3; k++) begin : g_comp
        logic signed [SW-1:0] w_acc;
        logic signed [RW-1:0] w_r;

        assign w_acc = SW'(r_pu[k]) + SW'(r_pv[k]) + SW'(r_pw[k]) + HALF_LSB;
        assign w_r   = w_acc[SW-1:FRAC];

        always_comb begin
            if (w_r > SAT_HI) begin
                n_dir[k] = SAT_HI[COMP_W-1:0];
            end else if (w_r < SAT_LO) begin
                n_dir[k] = SAT_LO[COMP_W-1:0];
            end else begin
                n_dir[k] = w_r[COMP_W-1:0];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Coefficients, then products, then sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a <= w_ss[FRAC+CW-1:FRAC];
            r_b <= i_cos_t;
            r_c <= w_sc[FRAC+CW-1:FRAC];
            for (int k = 0; k < 3; k++) begin
                r_pu[k]  <= r_a * signed'(i_right[COMP_W*k +: COMP_W]);
                r_pv[k]  <= r_b * signed'(i_up[COMP_W*k +: COMP_W]);
                r_pw[k]  <= r_c * signed'(i_back[COMP_W*k +: COMP_W]);
                r_dir[k] <= n_dir[k];
            end
        end
    end

    assign o_valid = r_v3;
    assign o_dx    = r_dir[0];
    assign o_dy    = r_dir[1];
    assign o_dz    = r_dir[2];

endmodule

FILE: tb/sv/tb_spherical_camera_ray_direction.sv
// Testbench for the spherical camera ray direction block: directed and random sample points,
// checked field by field against a behavioural predictor of the ray direction.
// Depends on scrd_pkg, the channel interfaces and the block itself.
`timescale 1ns / 100ps

module tb_spherical_camera_ray_direction;
    import scrd_pkg::*;

    localparam int LATENCY     = 16 + 63;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } t_dir;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               known;
        t_dir               dir;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    scrd_point_if point_ch();
    scrd_dir_if   dir_ch();
    scrd_cfg_if   cfg_ch();

    spherical_camera_ray_direction #(.SINCOS_STAGES(16)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (point_ch),
        .o_dir   (dir_ch),
        .i_cfg   (cfg_ch)
    );

    // Camera registers as the predictor sees them
    logic [13:0] cam_hres, cam_vres;
    logic [30:0] cam_pixel;
    logic [15:0] cam_az, cam_el;
    logic [47:0] cam_right, cam_up, cam_back;

    t_dir   pending_dirs[$];
    int     error_count;
    int     checked_count;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint atan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                             14668, 7334, 3667, 1833, 917, 458, 229, 115,
                             57, 29, 14, 7, 4, 2, 1, 0};

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, checked_count);
        error_count++;
    endtask

    function automatic longint angle_of(longint pt, longint lim, longint res);
        longint pix;
        longint r;
        pix = (cam_pixel == 0) ? 1 : longint'(cam_pixel);
        r   = (res == 0) ? 1 : res;
        return (pt * lim * 512) / (pix * r);
    endfunction

    function automatic longint wrap_angle(longint a);
        longint r;
        r = a % (longint'(360) * 65536);
        if (r < 0) r += longint'(360) * 65536;
        return r;
    endfunction

    // Rotation sine and cosine in Q.30 of an angle in [0, 360) degrees
    task automatic rotate_angle(input longint a, output longint sn, output longint cs);
        longint x, y, z, xs, ys;
        bit     flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (a <= longint'(90) * 65536) begin
            z = a;
        end else if (a < longint'(270) * 65536) begin
            z = a - longint'(180) * 65536;
            flip = 1;
        end else begin
            z = a - longint'(360) * 65536;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_q16[i];
            end else begin
                x += ys; y -= xs; z += atan_q16[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic logic signed [15:0] mix_component(longint a, longint b, longint c, int k);
        longint acc;
        acc = a * longint'($signed(cam_right[16*k +: 16]))
            + b * longint'($signed(cam_up[16*k +: 16]))
            + c * longint'($signed(cam_back[16*k +: 16]));
        acc = (acc + (longint'(1) << 29)) >>> 30;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[15:0];
    endfunction

    task automatic predict_direction(input logic signed [31:0] px, input logic signed [31:0] py,
                                     output t_dir d);
        longint phi, theta, sp, cp, st, ct, a, c;
        phi   = wrap_angle(longint'(180) * 65536 - angle_of(px, cam_az, cam_hres));
        theta = wrap_angle(longint'(90) * 65536 - angle_of(py, cam_el, cam_vres));
        rotate_angle(phi, sp, cp);
        rotate_angle(theta, st, ct);
        a = (st * sp) >>> 30;
        c = (st * cp) >>> 30;
        d.dx = mix_component(a, ct, c, 0);
        d.dy = mix_component(a, ct, c, 1);
        d.dz = mix_component(a, ct, c, 2);
    endtask

    // Compare each accepted direction with the oldest expectation
    always @(posedge i_clk) begin
        t_dir want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && dir_ch.valid && dir_ch.ready) begin
            if (pending_dirs.size() == 0) begin
                report_mismatch("unexpected direction item", 1, 0);
            end else begin
                want = pending_dirs.pop_front();
                if (dir_ch.direction_x !== want.dx)
                    report_mismatch("direction_x", dir_ch.direction_x, want.dx);
                if (dir_ch.direction_y !== want.dy)
                    report_mismatch("direction_y", dir_ch.direction_y, want.dy);
                if (dir_ch.direction_z !== want.dz)
                    report_mismatch("direction_z", dir_ch.direction_z, want.dz);
            end
            checked_count++;
        end
        dir_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Timeout guard
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Leave valid high after the accepting edge; the next item, an idle cycle or a drain
    // decides what it becomes
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input bit known, input t_dir given);
        t_dir d;
        while ($urandom_range(99) < send_idle_pct) begin
            point_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_direction(px, py, d);
        if (known) d = given;
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= px;
        point_ch.point_y <= py;
        do @(posedge i_clk); while (!point_ch.ready);
        pending_dirs.push_back(d);
    endtask

    task automatic drain();
        point_ch.valid <= 1'b0;
        while (pending_dirs.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Valid stays high between back-to-back writes; drop it after the last of a group
    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_HRES:      cam_hres  = value[13:0];
            CFG_VRES:      cam_vres  = value[13:0];
            CFG_PIXEL:     cam_pixel = value[30:0];
            CFG_AZIMUTH:   cam_az    = value[15:0];
            CFG_ELEVATION: cam_el    = value[15:0];
            CFG_RIGHT:     cam_right = value;
            CFG_UP:        cam_up    = value;
            default:       cam_back  = value;
        endcase
    endtask

    function automatic logic [47:0] random_basis();
        logic [47:0] v;
        v = {$urandom, $urandom};
        // Mostly unit-scale components, now and then anything
        if ($urandom_range(3) != 0)
            for (int k = 0; k < 3; k++) v[16*k +: 16] = $urandom_range(32768) - 16384;
        return v;
    endfunction

    task automatic random_points(input int count);
        logic signed [31:0] px, py;
        t_dir none;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: begin px = $urandom; py = $urandom; end
                1: begin
                    px = $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
                    py = $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
                end
                2: begin px = $signed($urandom_range(4096)) - 2048; py = $urandom; end
                default: begin
                    px = $signed($urandom) >>> $urandom_range(31);
                    py = $signed($urandom) >>> $urandom_range(31);
                end
            endcase
            send_point(px, py, 0, none);
        end
    endtask

    initial begin
        t_row rows[$];
        t_row r;
        t_dir none;
        error_count = 0;
        checked_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cam_hres = 640; cam_vres = 480; cam_pixel = 65536;
        cam_az = 15360; cam_el = 46080;
        cam_right = 48'd16384; cam_up = 48'd1073741824; cam_back = 48'd70368744177664;
        point_ch.valid = 0; point_ch.point_x = 0; point_ch.point_y = 0;
        cfg_ch.valid = 0; cfg_ch.index = CFG_HRES; cfg_ch.data = 0;
        dir_ch.ready = 1;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed table: centre looks down the negated back vector, extremes go through
        // the predictor
        rows.push_back('{0, 0, 1, '{16'sd0, 16'sd0, -16'sd16384}});
        rows.push_back('{32'sh7fffffff, 0, 0, '{0, 0, 0}});
        rows.push_back('{32'sh80000000, 0, 0, '{0, 0, 0}});
        rows.push_back('{0, 32'sh7fffffff, 0, '{0, 0, 0}});
        rows.push_back('{0, 32'sh80000000, 0, '{0, 0, 0}});
        rows.push_back('{32'sh80000000, 32'sh80000000, 0, '{0, 0, 0}});
        rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 0, '{0, 0, 0}});
        rows.push_back('{-1, 1, 0, '{0, 0, 0}});
        rows.push_back('{320 * 65536, 240 * 65536, 0, '{0, 0, 0}});
        rows.push_back('{-320 * 65536, -240 * 65536, 0, '{0, 0, 0}});
        rows.push_back('{160 * 65536, 120 * 65536, 0, '{0, 0, 0}});
        foreach (rows[i]) begin
            r = rows[i];
            send_point(r.px, r.py, r.known, r.dir);
        end
        drain();

        // Zero divisors and limits at the extremes
        write_reg(CFG_HRES, 0);
        write_reg(CFG_VRES, 0);
        write_reg(CFG_PIXEL, 0);
        write_reg(CFG_AZIMUTH, 46080);
        write_reg(CFG_ELEVATION, 0);
        write_reg(CFG_RIGHT, 48'hffff_ffff_ffff);
        write_reg(CFG_UP, 48'h7fff_7fff_7fff);
        write_reg(CFG_BACK, 48'h8000_8000_8000);
        cfg_ch.valid <= 1'b0;
        for (int i = 0; i < 8; i++) send_point(i * 3, -i * 5, 0, none);
        random_points(40);
        drain();

        // Phases with different settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            write_reg(CFG_HRES, (ph == 3) ? 8192 : $urandom_range(8192, 1));
            write_reg(CFG_VRES, (ph == 5) ? 1 : $urandom_range(8192, 1));
            write_reg(CFG_PIXEL, (ph == 6) ? 31'h7fffffff : $urandom_range(4 * 65536, 1));
            write_reg(CFG_AZIMUTH, $urandom_range(46080));
            write_reg(CFG_ELEVATION, (ph == 2) ? 46080 : $urandom_range(46080));
            write_reg(CFG_RIGHT, random_basis());
            write_reg(CFG_UP, random_basis());
            write_reg(CFG_BACK, random_basis());
            cfg_ch.valid <= 1'b0;
            random_points(70);
            // Hold off until the pipeline is empty, then resume
            if (ph == 4) begin
                point_ch.valid <= 1'b0;
                while (pending_dirs.size() != 0) @(posedge i_clk);
            end
            random_points(70);
            drain();
        end

        $display("Covered %0d directions over ten camera settings and four idling mixes.",
                 checked_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
